FILE: rtl/core/egnt_pkg.sv
// Package for the EQ gain normalize tuner: field widths, register reset values,
// mode and register codes, and the sequencer state type.
// No dependencies.
package egnt_pkg;

    localparam int DATA_W       = 16;
    localparam int BAND_COUNT_W = 5;
    localparam int MODE_W       = 2;
    localparam int SCORE_W      = 16;
    localparam int OUT_INDEX_W  = 4;
    localparam int CFG_INDEX_W  = 2;

    localparam int MAX_BANDS_DEF        = 16;
    localparam int NORMALIZE_PASSES_DEF = 1000;
    localparam int GAIN_WIDTH_DEF       = 16;

    localparam logic [BAND_COUNT_W-1:0] BAND_COUNT_RST     = 5'd10;
    localparam logic signed [DATA_W-1:0] MIN_GAIN_RST       = -16'sd2560;
    localparam logic signed [DATA_W-1:0] MAX_GAIN_RST       = 16'sd2560;
    localparam logic signed [DATA_W-1:0] SPEAKER_VOLUME_RST = 16'sd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_PROPOSE = 2'd0,
        MODE_REFINE  = 2'd1,
        MODE_CLEAR   = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BAND_COUNT     = 2'd0,
        CFG_MIN_GAIN       = 2'd1,
        CFG_MAX_GAIN       = 2'd2,
        CFG_SPEAKER_VOLUME = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY,
        ST_INIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_APPLY,
        ST_VOLUME,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

endpackage

FILE: rtl/core/eq_gain_normalize_tuner_unit.sv
// A band word is taken only while the sequencer is idle. The last band word starts
// NORMALIZE_PASSES mean-removal passes over the bands in use, each waiting on the divider,
// preceded by a copy of the next set when the best set is refreshed; results then leave one band at a time.
// Throughput is set by the serial mean divider and the single read port of the gain memory.
// Reset (rst_n low, async): registers take their reset values, both gain sets read as zero
// through per-entry valid bits; no clearing pass is needed.
// Top level; depends on egnt_pkg and egnt_div.
module eq_gain_normalize_tuner_unit #(
    parameter int MAX_BANDS        = egnt_pkg::MAX_BANDS_DEF,
    parameter int NORMALIZE_PASSES = egnt_pkg::NORMALIZE_PASSES_DEF,
    parameter int GAIN_WIDTH       = egnt_pkg::GAIN_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // band word channel
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [egnt_pkg::MODE_W-1:0]          mode,
    input  logic signed [egnt_pkg::DATA_W-1:0]   band_delta,
    input  logic [egnt_pkg::SCORE_W-1:0]         score,
    input  logic                                 last_band,
    // result word channel
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic                                 which_set,
    output logic [egnt_pkg::OUT_INDEX_W-1:0]     band_index,
    output logic signed [egnt_pkg::DATA_W-1:0]   band_gain,
    output logic signed [egnt_pkg::DATA_W-1:0]   new_volume,
    output logic                                 improved,
    output logic                                 last,
    // register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [egnt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [egnt_pkg::DATA_W-1:0]          cfg_data
);

    import egnt_pkg::*;

    // Widths. A working band value is a 16-bit gain plus a 16-bit delta (17 bits); the pass
    // sum grows by log2 of the band count; the mean total grows by log2 of the pass count.
    localparam int IDX_W   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CNT_W   = $clog2(MAX_BANDS + 1);
    localparam int GA_W    = IDX_W + 1;
    localparam int GM_DEPTH = 2 ** GA_W;
    localparam int WORK_W  = DATA_W + 1;
    localparam int DIFF_W  = WORK_W + 1;
    localparam int SUM_W   = WORK_W + $clog2(MAX_BANDS);
    localparam int PASS_W  = $clog2(NORMALIZE_PASSES + 1);
    localparam int TOT_W   = WORK_W + PASS_W + 1;
    localparam int VOL_W   = (GAIN_WIDTH > DATA_W) ? GAIN_WIDTH : DATA_W;
    localparam int SAT_W   = ((VOL_W > TOT_W) ? VOL_W : TOT_W) + 1;
    localparam int CMP_W   = (CNT_W > BAND_COUNT_W) ? CNT_W : BAND_COUNT_W;

    localparam logic signed [SAT_W-1:0] VOL_HI =
        {{(SAT_W - GAIN_WIDTH + 1){1'b0}}, {(GAIN_WIDTH - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] VOL_LO =
        {{(SAT_W - GAIN_WIDTH + 1){1'b1}}, {(GAIN_WIDTH - 1){1'b0}}};

    // Gain memory: lower half holds the next set, upper half the best set.
    // Entries carry a valid bit; an entry never written since reset or clear reads zero.
    logic [WORK_W-1:0] gain_mem [GM_DEPTH];
    logic [DATA_W-1:0] delta_mem [MAX_BANDS];

    logic              gm_re, gm_we;
    logic [GA_W-1:0]   gm_raddr, gm_waddr;
    logic [WORK_W-1:0] gm_wdata;
    logic [WORK_W-1:0] gm_rdata_reg;
    logic              gm_rvld_reg;
    logic              dm_re, dm_we;
    logic [IDX_W-1:0]  dm_raddr, dm_waddr;
    logic [DATA_W-1:0] dm_rdata_reg;

    logic [GM_DEPTH-1:0] gain_vld_reg, gain_vld_next;

    // sequencer and datapath state
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                      p1_vld_reg, p1_vld_next;
    logic [IDX_W-1:0]          p1_idx_reg, p1_idx_next;
    logic [IDX_W-1:0]          emit_idx_reg, emit_idx_next;
    logic [PASS_W-1:0]         pass_reg, pass_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [WORK_W-1:0]  mean_reg, mean_next;
    logic signed [TOT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic                      sel_reg, sel_next;
    logic                      improved_reg, improved_next;
    logic [CNT_W-1:0]          band_counter_reg, band_counter_next;
    logic [SCORE_W-1:0]        best_score_reg, best_score_next;
    logic signed [VOL_W-1:0]   next_volume_reg, next_volume_next;
    logic signed [VOL_W-1:0]   best_volume_reg, best_volume_next;

    // configuration registers
    logic [BAND_COUNT_W-1:0]   band_count_reg, band_count_next;
    logic signed [DATA_W-1:0]  min_gain_reg, min_gain_next;
    logic signed [DATA_W-1:0]  max_gain_reg, max_gain_next;
    logic signed [DATA_W-1:0]  speaker_volume_reg, speaker_volume_next;

    // result register
    logic                      res_valid_reg, res_valid_next;
    logic                      res_which_reg, res_which_next;
    logic [OUT_INDEX_W-1:0]    res_index_reg, res_index_next;
    logic signed [DATA_W-1:0]  res_gain_reg, res_gain_next;
    logic signed [DATA_W-1:0]  res_vol_reg, res_vol_next;
    logic                      res_improved_reg, res_improved_next;
    logic                      res_last_reg, res_last_next;

    // combinational helpers
    logic                      item_accept;
    logic                      clr_sets;
    logic                      div_start, div_done;
    logic signed [SUM_W-1:0]   div_quot;
    logic signed [WORK_W-1:0]  mean_new;
    logic [IDX_W-1:0]          rd_idx;
    logic [CNT_W-1:0]          phase_lim;
    logic                      issue;
    logic signed [WORK_W-1:0]  g_rd;
    logic signed [WORK_W-1:0]  d_rd;
    logic signed [WORK_W-1:0]  w_init;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  min_x, max_x;
    logic signed [DIFF_W-1:0]  clamped;
    logic signed [WORK_W-1:0]  clamped_w;
    logic signed [VOL_W-1:0]   vol_base;
    logic signed [SAT_W-1:0]   vol_sum;
    logic signed [SAT_W-1:0]   vol_sat;
    logic [CMP_W-1:0]          bc_wide;
    logic [CNT_W-1:0]          used_bands;
    logic                      emit_is_last;

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    // bands in use: zero acts as one, anything above the memory depth as the depth
    assign bc_wide    = CMP_W'(band_count_reg);
    assign used_bands = (bc_wide == '0) ? CNT_W'(1) :
                        (bc_wide > CMP_W'(MAX_BANDS)) ? CNT_W'(MAX_BANDS) : CNT_W'(bc_wide);

    // read/modify/write pipeline: issue a read at rd_cnt, write it back in the next cycle
    assign rd_idx    = rd_cnt_reg[IDX_W-1:0];
    assign phase_lim = (state_reg == ST_COPY) ? CNT_W'(MAX_BANDS) : n_reg;
    assign issue     = (rd_cnt_reg < phase_lim);

    assign g_rd   = gm_rvld_reg ? $signed(gm_rdata_reg) : '0;
    assign d_rd   = (CNT_W'(p1_idx_reg) < band_counter_reg) ?
                    WORK_W'($signed(dm_rdata_reg)) : '0;
    assign w_init = g_rd + d_rd;

    // subtract the mean, then clamp; a band below min wins over one above max
    assign diff      = DIFF_W'(g_rd) - DIFF_W'(mean_reg);
    assign min_x     = DIFF_W'(min_gain_reg);
    assign max_x     = DIFF_W'(max_gain_reg);
    assign clamped   = (diff < min_x) ? min_x : ((diff > max_x) ? max_x : diff);
    assign clamped_w = WORK_W'(clamped);

    assign mean_new = WORK_W'(div_quot);

    // volume: propose starts from the applied speaker volume, refine from the best volume
    assign vol_base = sel_reg ? best_volume_reg : VOL_W'(speaker_volume_reg);
    assign vol_sum  = SAT_W'(vol_base) + SAT_W'(total_reg);
    assign vol_sat  = (vol_sum > VOL_HI) ? VOL_HI : ((vol_sum < VOL_LO) ? VOL_LO : vol_sum);

    assign emit_is_last = (CNT_W'(emit_idx_reg) == (n_reg - CNT_W'(1)));

    egnt_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (n_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next          = state_reg;
        rd_cnt_next         = rd_cnt_reg;
        p1_vld_next         = 1'b0;
        p1_idx_next         = p1_idx_reg;
        emit_idx_next       = emit_idx_reg;
        pass_next           = pass_reg;
        sum_next            = sum_reg;
        mean_next           = mean_reg;
        total_next          = total_reg;
        n_next              = n_reg;
        sel_next            = sel_reg;
        improved_next       = improved_reg;
        band_counter_next   = band_counter_reg;
        best_score_next     = best_score_reg;
        next_volume_next    = next_volume_reg;
        best_volume_next    = best_volume_reg;
        band_count_next     = band_count_reg;
        min_gain_next       = min_gain_reg;
        max_gain_next       = max_gain_reg;
        speaker_volume_next = speaker_volume_reg;
        res_valid_next      = res_valid_reg;
        res_which_next      = res_which_reg;
        res_index_next      = res_index_reg;
        res_gain_next       = res_gain_reg;
        res_vol_next        = res_vol_reg;
        res_improved_next   = res_improved_reg;
        res_last_next       = res_last_reg;
        gm_re               = 1'b0;
        gm_raddr            = {sel_reg, rd_idx};
        gm_we               = 1'b0;
        gm_waddr            = {sel_reg, p1_idx_reg};
        gm_wdata            = clamped_w;
        dm_re               = 1'b0;
        dm_raddr            = rd_idx;
        dm_we               = 1'b0;
        dm_waddr            = band_counter_reg[IDX_W-1:0];
        clr_sets            = 1'b0;
        div_start           = 1'b0;

        // the user must write registers only while idle; the block itself does not enforce it
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BAND_COUNT:     band_count_next     = cfg_data[BAND_COUNT_W-1:0];
                CFG_MIN_GAIN:       min_gain_next       = cfg_data;
                CFG_MAX_GAIN:       max_gain_next       = cfg_data;
                CFG_SPEAKER_VOLUME: speaker_volume_next = cfg_data;
                default: ;
            endcase
        end

        // drop the result word once taken
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    case (mode)
                        MODE_CLEAR:
                        begin
                            clr_sets          = 1'b1;
                            best_score_next   = '0;
                            next_volume_next  = VOL_W'(speaker_volume_reg);
                            best_volume_next  = VOL_W'(speaker_volume_reg);
                            band_counter_next = '0;
                        end
                        MODE_PROPOSE, MODE_REFINE:
                        begin
                            // buffer the delta; drop it when the buffer is full
                            if (band_counter_reg < CNT_W'(MAX_BANDS))
                            begin
                                dm_we             = 1'b1;
                                band_counter_next = band_counter_reg + CNT_W'(1);
                            end
                            if (last_band)
                            begin
                                n_next        = used_bands;
                                sel_next      = (mode == MODE_REFINE);
                                improved_next = 1'b0;
                                sum_next      = '0;
                                total_next    = '0;
                                pass_next     = '0;
                                rd_cnt_next   = '0;
                                state_next    = ST_INIT;
                                if ((mode == MODE_PROPOSE) && (score > best_score_reg))
                                begin
                                    improved_next    = 1'b1;
                                    best_score_next  = score;
                                    best_volume_next = next_volume_reg;
                                    state_next       = ST_COPY;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_COPY, ST_INIT, ST_APPLY:
            begin
                if (issue)
                begin
                    gm_re       = 1'b1;
                    gm_raddr    = {(state_reg == ST_COPY) ? 1'b0 : sel_reg, rd_idx};
                    dm_re       = (state_reg == ST_INIT);
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    p1_vld_next = 1'b1;
                    p1_idx_next = rd_idx;
                end
                if (p1_vld_reg)
                begin
                    gm_we = 1'b1;
                    case (state_reg)
                        ST_COPY:
                        begin
                            gm_waddr = {1'b1, p1_idx_reg};
                            gm_wdata = g_rd;
                        end
                        ST_INIT:
                        begin
                            gm_wdata = w_init;
                            sum_next = sum_reg + SUM_W'(w_init);
                        end
                        default:
                        begin
                            gm_wdata = clamped_w;
                            sum_next = sum_reg + SUM_W'(clamped_w);
                        end
                    endcase
                end
                if (!issue && !p1_vld_reg)
                begin
                    rd_cnt_next = '0;
                    case (state_reg)
                        ST_COPY: state_next = ST_INIT;
                        ST_INIT: state_next = ST_DIV_GO;
                        default:
                        begin
                            if (pass_reg == PASS_W'(NORMALIZE_PASSES - 1))
                            begin
                                state_next = ST_VOLUME;
                            end
                            else
                            begin
                                pass_next  = pass_reg + PASS_W'(1);
                                state_next = ST_DIV_GO;
                            end
                        end
                    endcase
                end
            end

            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    mean_next  = mean_new;
                    total_next = total_reg + TOT_W'(mean_new);
                    sum_next   = '0;
                    state_next = ST_APPLY;
                end
            end

            ST_VOLUME:
            begin
                if (sel_reg)
                begin
                    best_volume_next = VOL_W'(vol_sat);
                end
                else
                begin
                    next_volume_next = VOL_W'(vol_sat);
                end
                band_counter_next = '0;
                emit_idx_next     = '0;
                state_next        = ST_EMIT_RD;
            end

            ST_EMIT_RD:
            begin
                gm_re      = 1'b1;
                gm_raddr   = {sel_reg, emit_idx_reg};
                state_next = ST_EMIT_WR;
            end

            ST_EMIT_WR:
            begin
                // read data holds until the next read, so wait here for a free slot
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next    = 1'b1;
                    res_which_next    = sel_reg;
                    res_index_next    = OUT_INDEX_W'(emit_idx_reg);
                    res_gain_next     = DATA_W'(g_rd);
                    res_vol_next      = DATA_W'(sel_reg ? best_volume_reg : next_volume_reg);
                    res_improved_next = improved_reg;
                    res_last_next     = emit_is_last;
                    if (emit_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // valid bits: clear mode wipes both sets at once, any write marks its entry
    always_comb
    begin
        gain_vld_next = gain_vld_reg;
        if (clr_sets)
        begin
            gain_vld_next = '0;
        end
        if (gm_we)
        begin
            gain_vld_next[gm_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gm_we)
        begin
            gain_mem[gm_waddr] <= gm_wdata;
        end
        if (gm_re)
        begin
            gm_rdata_reg <= gain_mem[gm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            delta_mem[dm_waddr] <= band_delta;
        end
        if (dm_re)
        begin
            dm_rdata_reg <= delta_mem[dm_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            rd_cnt_reg         <= '0;
            p1_vld_reg         <= 1'b0;
            p1_idx_reg         <= '0;
            emit_idx_reg       <= '0;
            pass_reg           <= '0;
            sum_reg            <= '0;
            mean_reg           <= '0;
            total_reg          <= '0;
            n_reg              <= CNT_W'(1);
            sel_reg            <= 1'b0;
            improved_reg       <= 1'b0;
            band_counter_reg   <= '0;
            best_score_reg     <= '0;
            next_volume_reg    <= '0;
            best_volume_reg    <= '0;
            band_count_reg     <= BAND_COUNT_RST;
            min_gain_reg       <= MIN_GAIN_RST;
            max_gain_reg       <= MAX_GAIN_RST;
            speaker_volume_reg <= SPEAKER_VOLUME_RST;
            res_valid_reg      <= 1'b0;
            gain_vld_reg       <= '0;
            gm_rvld_reg        <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            rd_cnt_reg         <= rd_cnt_next;
            p1_vld_reg         <= p1_vld_next;
            p1_idx_reg         <= p1_idx_next;
            emit_idx_reg       <= emit_idx_next;
            pass_reg           <= pass_next;
            sum_reg            <= sum_next;
            mean_reg           <= mean_next;
            total_reg          <= total_next;
            n_reg              <= n_next;
            sel_reg            <= sel_next;
            improved_reg       <= improved_next;
            band_counter_reg   <= band_counter_next;
            best_score_reg     <= best_score_next;
            next_volume_reg    <= next_volume_next;
            best_volume_reg    <= best_volume_next;
            band_count_reg     <= band_count_next;
            min_gain_reg       <= min_gain_next;
            max_gain_reg       <= max_gain_next;
            speaker_volume_reg <= speaker_volume_next;
            res_valid_reg      <= res_valid_next;
            gain_vld_reg       <= gain_vld_next;
            if (gm_re)
            begin
                gm_rvld_reg <= gain_vld_reg[gm_raddr];
            end
        end
    end

    // result payload holds while stalled; no reset needed
    always_ff @(posedge clk)
    begin
        res_which_reg    <= res_which_next;
        res_index_reg    <= res_index_next;
        res_gain_reg     <= res_gain_next;
        res_vol_reg      <= res_vol_next;
        res_improved_reg <= res_improved_next;
        res_last_reg     <= res_last_next;
    end

    assign res_valid  = res_valid_reg;
    assign which_set  = res_which_reg;
    assign band_index = res_index_reg;
    assign band_gain  = res_gain_reg;
    assign new_volume = res_vol_reg;
    assign improved   = res_improved_reg;
    assign last       = res_last_reg;

endmodule

FILE: rtl/core/egnt_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero. Standalone; no package dependency.
module egnt_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  mag_reg, mag_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              trial_ge;
    logic [NUM_W-1:0]  num_abs;

    assign trial     = {rem_reg, mag_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign num_abs   = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = num_abs;
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[NUM_W-1];
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one quotient bit, keep the partial remainder below den
            mag_next  = {mag_reg[NUM_W-2:0], trial_ge};
            rem_next  = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            neg_reg  <= 1'b0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mag_reg  <= mag_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            neg_reg  <= neg_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? $signed(~mag_reg + NUM_W'(1)) : $signed(mag_reg);

endmodule

FILE: tb/tb_eq_gain_normalize_tuner_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for eq_gain_normalize_tuner_unit: a bursty driver sends band words,
// a monitor checks every result word against a built-in model of the gain tuner.
// Depends on egnt_pkg and the tuner RTL.
module tb_eq_gain_normalize_tuner_unit;
    import egnt_pkg::*;

    localparam int GAIN_BANDS    = MAX_BANDS_DEF;
    localparam int PASSES        = NORMALIZE_PASSES_DEF;
    localparam longint VOL_MAX   = (longint'(1) << (GAIN_WIDTH_DEF - 1)) - 1;
    localparam longint VOL_MIN   = -(longint'(1) << (GAIN_WIDTH_DEF - 1));
    // mode code the block has no use for; such words must vanish without a trace
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RESET_CYCLES  = 5;
    // margin for a word that makes no result to finish before register writes
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    // slowest legal silence: 16 bands, 1000 passes, each with a full divide, plus the copy
    // of the best set; allow several times that
    localparam int IDLE_LIMIT    = 250000;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DATA_W-1:0]  band_delta;
        logic [SCORE_W-1:0] score;
        logic               last_band;
    } band_word_t;

    typedef struct packed {
        logic                   which_set;
        logic [OUT_INDEX_W-1:0] band_index;
        logic [DATA_W-1:0]      band_gain;
        logic [DATA_W-1:0]      new_volume;
        logic                   improved;
        logic                   last;
    } band_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    logic [MODE_W-1:0]      mode = '0;
    logic [DATA_W-1:0]      band_delta = '0;
    logic [SCORE_W-1:0]     score = '0;
    logic                   last_band = 1'b0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    logic                   which_set;
    logic [OUT_INDEX_W-1:0] band_index;
    logic [DATA_W-1:0]      band_gain;
    logic [DATA_W-1:0]      new_volume;
    logic                   improved;
    logic                   last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_BAND_COUNT;
    logic [DATA_W-1:0]      cfg_data = '0;

    eq_gain_normalize_tuner_unit dut (.*);

    initial begin
        forever #4 clk = ~clk;
    end

    // Band words waiting for the driver, and result words the model says must come out.
    band_word_t   band_word_q[$];
    band_result_t expected_band_q[$];

    // Model copy of the register file.
    logic [BAND_COUNT_W-1:0] band_cfg     = BAND_COUNT_RST;
    logic signed [DATA_W-1:0] gain_floor   = MIN_GAIN_RST;
    logic signed [DATA_W-1:0] gain_ceiling = MAX_GAIN_RST;
    logic signed [DATA_W-1:0] speaker_cfg  = SPEAKER_VOLUME_RST;

    // Model copy of the tuner state.
    logic signed [DATA_W-1:0] next_gain_set [0:GAIN_BANDS-1];
    logic signed [DATA_W-1:0] best_gain_set [0:GAIN_BANDS-1];
    logic signed [DATA_W-1:0] delta_store   [0:GAIN_BANDS-1];
    logic [SCORE_W-1:0]       best_score_seen;
    logic signed [DATA_W-1:0] next_vol;
    logic signed [DATA_W-1:0] best_vol;
    int unsigned              bands_buffered;

    int mismatch_count = 0;
    int idle_cycles = 0;

    function automatic logic [DATA_W-1:0] saturate_volume(input longint x);
        if (x > VOL_MAX)
            return DATA_W'(VOL_MAX);
        if (x < VOL_MIN)
            return DATA_W'(VOL_MIN);
        return DATA_W'(x);
    endfunction

    // Fold the buffered deltas into one set, run the mean-removal passes at full precision,
    // write the set back and return the sum of all removed means.
    function automatic longint normalize_gain_set(input logic use_best, input int unsigned n_used);
        longint w [0:GAIN_BANDS-1];
        longint sum_all;
        longint mean;
        longint total;
        longint divisor;
        int unsigned i;
        int p;
        total = 0;
        divisor = n_used;
        for (i = 0; i < n_used; i++) begin
            w[i] = use_best ? longint'(best_gain_set[i]) : longint'(next_gain_set[i]);
            if (i < bands_buffered)
                w[i] += longint'(delta_store[i]);
        end
        for (p = 0; p < PASSES; p++) begin
            sum_all = 0;
            for (i = 0; i < n_used; i++)
                sum_all += w[i];
            mean = sum_all / divisor;
            for (i = 0; i < n_used; i++) begin
                w[i] -= mean;
                // floor wins when the limits are crossed
                if (w[i] < longint'(gain_floor))
                    w[i] = longint'(gain_floor);
                else if (w[i] > longint'(gain_ceiling))
                    w[i] = longint'(gain_ceiling);
            end
            total += mean;
        end
        for (i = 0; i < n_used; i++) begin
            if (use_best)
                best_gain_set[i] = DATA_W'(w[i]);
            else
                next_gain_set[i] = DATA_W'(w[i]);
        end
        return total;
    endfunction

    // Advance the model by one accepted band word; queue the result words it produces.
    task automatic predict_band_word(input band_word_t w);
        int unsigned n_used;
        int unsigned i;
        longint total;
        logic improved_now;
        logic use_best;
        logic [DATA_W-1:0] vol;
        band_result_t r;
        if (w.mode == MODE_CLEAR) begin
            for (i = 0; i < GAIN_BANDS; i++) begin
                next_gain_set[i] = '0;
                best_gain_set[i] = '0;
            end
            best_score_seen = '0;
            next_vol = speaker_cfg;
            best_vol = speaker_cfg;
            bands_buffered = 0;
        end else if (w.mode != MODE_UNUSED) begin
            // drop deltas once the buffer is full
            if (bands_buffered < GAIN_BANDS) begin
                delta_store[bands_buffered] = w.band_delta;
                bands_buffered++;
            end
            if (w.last_band) begin
                n_used = (band_cfg == 0) ? 1 :
                         (band_cfg > GAIN_BANDS) ? GAIN_BANDS : band_cfg;
                improved_now = 1'b0;
                use_best = (w.mode == MODE_REFINE);
                if (!use_best) begin
                    if (w.score > best_score_seen) begin
                        for (i = 0; i < GAIN_BANDS; i++)
                            best_gain_set[i] = next_gain_set[i];
                        best_score_seen = w.score;
                        best_vol = next_vol;
                        improved_now = 1'b1;
                    end
                    total = normalize_gain_set(1'b0, n_used);
                    next_vol = saturate_volume(longint'(speaker_cfg) + total);
                    vol = next_vol;
                end else begin
                    total = normalize_gain_set(1'b1, n_used);
                    best_vol = saturate_volume(longint'(best_vol) + total);
                    vol = best_vol;
                end
                bands_buffered = 0;
                for (i = 0; i < n_used; i++) begin
                    r.which_set  = use_best;
                    r.band_index = OUT_INDEX_W'(i);
                    r.band_gain  = use_best ? best_gain_set[i] : next_gain_set[i];
                    r.new_volume = vol;
                    r.improved   = improved_now;
                    r.last       = (i == n_used - 1);
                    expected_band_q.insert(expected_band_q.size(), r);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Driver: send queued words in bursts of random length with random gaps between.
    // Predict at the edge that accepts a word, then hold or advance the payload.
    // ---------------------------------------------------------------------------------
    band_word_t offered_word;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && !item_stall)
                predict_band_word(offered_word);
            if (!item_valid || !item_stall) begin
                if (gap_left == 0 && band_word_q.size() > 0) begin
                    offered_word = band_word_q.pop_front();
                    item_valid <= 1'b1;
                    mode       <= offered_word.mode;
                    band_delta <= offered_word.band_delta;
                    score      <= offered_word.score;
                    last_band  <= offered_word.last_band;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        // about a quarter of bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    item_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Result stall: a style redrawn at random intervals (none, heavy, light, periodic).
    // Once, while plenty of words still wait, hold off for HOLD_CYCLES so the block
    // backs up and stalls its input.
    // ---------------------------------------------------------------------------------
    int  style_left = 0;
    int  stall_style = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk) begin
        if (style_left <= 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(16, 96);
        end else begin
            style_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_stall <= 1'b1;
        end else if (!hold_done && res_valid && band_word_q.size() > 20) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            res_stall <= 1'b1;
        end else begin
            case (stall_style)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 1) == 0);
                2:       res_stall <= ($urandom_range(0, 4) == 0);
                default: res_stall <= ((style_left % 8) < 5);
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Monitor: compare each accepted result word with the oldest expectation.
    // ---------------------------------------------------------------------------------
    band_result_t want_result;

    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            if (expected_band_q.size() == 0) begin
                $error("result word with none expected: band_index %0d band_gain %0d",
                       band_index, $signed(band_gain));
                mismatch_count++;
            end else begin
                want_result = expected_band_q.pop_front();
                if (which_set !== want_result.which_set) begin
                    $error("which_set: expected %0d, got %0d", want_result.which_set, which_set);
                    mismatch_count++;
                end
                if (band_index !== want_result.band_index) begin
                    $error("band_index: expected %0d, got %0d", want_result.band_index,
                           band_index);
                    mismatch_count++;
                end
                if (band_gain !== want_result.band_gain) begin
                    $error("band_gain: expected %0d, got %0d", $signed(want_result.band_gain),
                           $signed(band_gain));
                    mismatch_count++;
                end
                if (new_volume !== want_result.new_volume) begin
                    $error("new_volume: expected %0d, got %0d", $signed(want_result.new_volume),
                           $signed(new_volume));
                    mismatch_count++;
                end
                if (improved !== want_result.improved) begin
                    $error("improved: expected %0d, got %0d", want_result.improved, improved);
                    mismatch_count++;
                end
                if (last !== want_result.last) begin
                    $error("last: expected %0d, got %0d", want_result.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no channel moves a word.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("[eq_gain_normalize_tuner_unit] ERROR");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------
    task automatic queue_band_word(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] d,
                                   input logic [SCORE_W-1:0] s, input logic l);
        band_word_t w;
        w.mode = m;
        w.band_delta = d;
        w.score = s;
        w.last_band = l;
        band_word_q.insert(band_word_q.size(), w);
    endtask

    // Small deltas half the time, with extremes and full-width values mixed in.
    function automatic logic [DATA_W-1:0] random_delta();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return DATA_W'($urandom);
            default: return DATA_W'($urandom_range(0, 2048) - 1024);
        endcase
    endfunction

    function automatic logic [SCORE_W-1:0] random_score();
        return ($urandom_range(0, 1) == 0) ? SCORE_W'($urandom) : SCORE_W'($urandom_range(0, 200));
    endfunction

    // Write one register and mirror it in the model; only called while the block is idle.
    task automatic write_tuner_register(input cfg_index_t idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BAND_COUNT:     band_cfg = data[BAND_COUNT_W-1:0];
            CFG_MIN_GAIN:       gain_floor = data;
            CFG_MAX_GAIN:       gain_ceiling = data;
            CFG_SPEAKER_VOLUME: speaker_cfg = data;
            default:            ;
        endcase
    endtask

    task automatic configure_tuner(input logic [DATA_W-1:0] bands, input logic [DATA_W-1:0] lo,
                                   input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] vol);
        write_tuner_register(CFG_BAND_COUNT, bands);
        write_tuner_register(CFG_MIN_GAIN, lo);
        write_tuner_register(CFG_MAX_GAIN, hi);
        write_tuner_register(CFG_SPEAKER_VOLUME, vol);
    endtask

    // Wait until every word is sent and every expected result is back, then let the
    // block finish any word that makes no result. Sample on the falling edge so the
    // driver's and monitor's updates of the rising edge are settled.
    task automatic drain_and_settle();
        @(negedge clk);
        while (band_word_q.size() != 0 || item_valid || expected_band_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------
    initial begin
        int phase;
        int budget;
        int taken;
        int roll;
        int len;
        int used;
        int j;
        int bands;
        logic [MODE_W-1:0] set_mode;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;

        for (j = 0; j < GAIN_BANDS; j++) begin
            next_gain_set[j] = '0;
            best_gain_set[j] = '0;
            delta_store[j] = '0;
        end
        best_score_seen = '0;
        next_vol = '0;
        best_vol = '0;
        bands_buffered = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Two bands, default limits. Extreme deltas whose sum -1 truncates to a zero mean,
        // a third delta past the band count, top score so the best set takes a copy.
        configure_tuner(16'd2, DATA_W'(-2560), 16'd2560, 16'd256);
        queue_band_word(MODE_PROPOSE, 16'h7FFF, 16'hFFFF, 1'b0);
        queue_band_word(MODE_PROPOSE, 16'h8000, 16'hFFFF, 1'b0);
        queue_band_word(MODE_PROPOSE, 16'd5, 16'hFFFF, 1'b1);
        // fewer deltas than bands, score zero: no improvement
        queue_band_word(MODE_PROPOSE, 16'd300, 16'h0000, 1'b1);
        queue_band_word(MODE_REFINE, 16'hFFFF, 16'h1234, 1'b0);
        queue_band_word(MODE_REFINE, 16'd1, 16'h4321, 1'b1);
        // unused mode is ignored, clear loads both volumes from the speaker volume
        queue_band_word(MODE_UNUSED, 16'h5A5A, 16'hA5A5, 1'b1);
        queue_band_word(MODE_CLEAR, 16'h7FFF, 16'hFFFF, 1'b1);
        drain_and_settle();

        // Band count zero acts as one; full-range limits; volume saturates high.
        configure_tuner(16'd0, 16'h8000, 16'h7FFF, 16'h7FFF);
        queue_band_word(MODE_PROPOSE, 16'h7FFF, 16'd1, 1'b1);
        drain_and_settle();

        // Refine from a cleared best set at the lowest volume: saturates low.
        write_tuner_register(CFG_SPEAKER_VOLUME, 16'h8000);
        queue_band_word(MODE_CLEAR, 16'd0, 16'd0, 1'b0);
        queue_band_word(MODE_REFINE, 16'h8000, 16'd0, 1'b1);
        drain_and_settle();

        // Band count above the maximum acts as the maximum; crossed limits; seventeen
        // deltas so the last one overflows the buffer and is dropped.
        configure_tuner(16'd31, 16'd100, DATA_W'(-100), 16'h0100);
        for (j = 0; j < GAIN_BANDS + 1; j++)
            queue_band_word(MODE_PROPOSE, (j % 2 == 0) ? 16'h8000 : 16'h7FFF, 16'hFFFF,
                            (j == GAIN_BANDS));
        drain_and_settle();

        // Random phases: mostly well-formed sets with random content, some noise.
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       bands = 3;
                1:       bands = 1;
                2:       bands = GAIN_BANDS;
                3:       bands = $urandom_range(2, 5);
                default: bands = $urandom_range(4, 8);
            endcase
            used = (bands == 0) ? 1 : (bands > GAIN_BANDS) ? GAIN_BANDS : bands;
            // full-size sets are slow; keep them few
            budget = (used >= GAIN_BANDS) ? 36 : 52;
            case (phase % 3)
                0: begin
                    lo = DATA_W'(0 - $urandom_range(256, 3000));
                    hi = DATA_W'($urandom_range(256, 3000));
                end
                1: begin
                    lo = DATA_W'($urandom);
                    hi = DATA_W'($urandom);
                end
                default: begin
                    lo = 16'h8000;
                    hi = 16'h7FFF;
                end
            endcase
            configure_tuner(DATA_W'(bands), lo, hi, DATA_W'($urandom));

            taken = 0;
            while (taken < budget) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    queue_band_word(MODE_CLEAR, random_delta(), random_score(),
                                    1'($urandom_range(0, 1)));
                    taken++;
                end else if (roll < 13) begin
                    // ignored by the block, so not counted
                    queue_band_word(MODE_UNUSED, random_delta(), random_score(),
                                    1'($urandom_range(0, 1)));
                end else if (roll < 17) begin
                    // stray delta that leaks into the next set
                    queue_band_word(MODE_W'($urandom_range(0, 1)), random_delta(),
                                    random_score(), 1'b0);
                    taken++;
                end else begin
                    set_mode = ($urandom_range(0, 2) == 0) ? MODE_REFINE : MODE_PROPOSE;
                    len = (used > 8) ? $urandom_range(used - 4, used + 4)
                                     : $urandom_range(1, used + 10);
                    for (j = 0; j < len; j++)
                        queue_band_word((j == len - 1) ? set_mode : MODE_W'($urandom_range(0, 1)),
                                        random_delta(), random_score(), (j == len - 1));
                    taken += len;
                end
            end
            drain_and_settle();
        end

        if (mismatch_count == 0)
            $display("[eq_gain_normalize_tuner_unit] OK");
        else
            $display("[eq_gain_normalize_tuner_unit] ERROR");
        $finish;
    end

endmodule
